@@ hw/rtl/sts_pkg.sv @@
// Shared types and constants for the sorted name/phone table.
// Used by sts_mem, sts_seq and sorted_table_search_insert; depends on nothing.
`timescale 1ns / 1ps

package sts_pkg;

	localparam int DEPTH     = 64;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = ADDR_W + 1;
	localparam int KEY_W     = 64;
	localparam int PHONE_W   = 34;
	localparam int KEY_CHARS = 8;

	// only the leading KEY_CHARS characters of a name take part in ordering
	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (KEY_W - 8 * KEY_CHARS);

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_SEARCH = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_SHIFT,
		ST_INS,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [PHONE_W-1:0] phone;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic               found;
		logic               inserted;
		logic               table_full;
		logic [ADDR_W-1:0]  position;
		logic [KEY_W-1:0]   key_out;
		logic [PHONE_W-1:0] phone_out;
		logic [CNT_W-1:0]   count_out;
	} result_t;

endpackage

@@ hw/rtl/sts_mem.sv @@
// Table storage: one write port, one read port with registered read data.
// Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_mem (
	input  logic              clk,
	input  sts_pkg::mem_req_t req,
	output sts_pkg::entry_t   rdata
);

	sts_pkg::entry_t mem_q [sts_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end

endmodule

@@ hw/rtl/sts_seq.sv @@
// Sequencer for the sorted table: binary search probes, shift-up insert,
// indexed read. Drives sts_mem through a request struct. Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  sts_pkg::kind_t                    kind,
	input  logic [sts_pkg::KEY_W-1:0]         name_key,
	input  logic [sts_pkg::PHONE_W-1:0]       phone,
	input  logic [sts_pkg::ADDR_W-1:0]        index,
	output sts_pkg::mem_req_t                 mem_req,
	input  sts_pkg::entry_t                   mem_rdata,
	output logic                              res_valid,
	input  logic                              res_ready,
	output sts_pkg::result_t                  res
);

	localparam int CW = sts_pkg::CNT_W;
	localparam int AW = sts_pkg::ADDR_W;

	sts_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q;

	sts_pkg::kind_t              kind_q;
	logic [sts_pkg::KEY_W-1:0]   key_q;
	logic [sts_pkg::PHONE_W-1:0] phone_q;
	logic [CW-1:0]               lo_q;
	logic [CW-1:0]               hip1_q;   // high bound plus one
	logic [AW-1:0]               mid_q;
	logic [CW-1:0]               sh_q;     // shift destination
	logic [AW-1:0]               pos_q;
	logic                        found_q;
	logic                        ins_q;
	logic                        full_q;
	logic [sts_pkg::KEY_W-1:0]   kout_q;
	logic [sts_pkg::PHONE_W-1:0] pout_q;

	logic [CW:0]   mid_sum;
	logic [AW-1:0] mid;
	logic          in_range;
	logic          is_full;
	logic          key_eq;
	logic          key_lt;
	logic          more_shift;

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hip1_q} - (CW + 1)'(1);
	assign mid        = mid_sum[AW:1];
	assign in_range   = lo_q < hip1_q;
	assign is_full    = count_q == CW'(sts_pkg::DEPTH);
	assign key_eq     = mem_rdata.key == key_q;
	assign key_lt     = mem_rdata.key < key_q;
	assign more_shift = (sh_q - CW'(1)) > {1'b0, pos_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (kind)
						sts_pkg::KIND_CLEAR:  state_d = sts_pkg::ST_DONE;
						sts_pkg::KIND_ADD:    state_d = is_full ? sts_pkg::ST_DONE
						                                        : sts_pkg::ST_PROBE;
						sts_pkg::KIND_SEARCH: state_d = sts_pkg::ST_PROBE;
						sts_pkg::KIND_READ:   state_d = ({1'b0, index} < count_q)
						                                ? sts_pkg::ST_RD_WAIT
						                                : sts_pkg::ST_DONE;
						default:              state_d = sts_pkg::ST_DONE;
					endcase
				end
			end
			sts_pkg::ST_PROBE: begin
				priority if (in_range) begin
					state_d = sts_pkg::ST_CMP;
				end else if (is_full) begin
					state_d = sts_pkg::ST_DONE;
				end else if (count_q > lo_q) begin
					state_d = sts_pkg::ST_SHIFT;
				end else begin
					state_d = sts_pkg::ST_INS;
				end
			end
			sts_pkg::ST_CMP: begin
				state_d = (kind_q == sts_pkg::KIND_SEARCH && key_eq) ? sts_pkg::ST_DONE
				                                                     : sts_pkg::ST_PROBE;
			end
			sts_pkg::ST_SHIFT:   state_d = more_shift ? sts_pkg::ST_SHIFT : sts_pkg::ST_INS;
			sts_pkg::ST_INS:     state_d = sts_pkg::ST_DONE;
			sts_pkg::ST_RD_WAIT: state_d = sts_pkg::ST_DONE;
			sts_pkg::ST_DONE:    state_d = res_ready ? sts_pkg::ST_IDLE : sts_pkg::ST_DONE;
			default:             state_d = sts_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory port
	always_comb begin
		in_ready      = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = pos_q;
		mem_req.wdata = '{key: key_q, phone: phone_q};
		mem_req.raddr = mid;
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				mem_req.raddr = index;
			end
			sts_pkg::ST_PROBE: begin
				// search over: prefetch the last entry for the shift
				mem_req.raddr = in_range ? mid : AW'(count_q - CW'(1));
			end
			sts_pkg::ST_SHIFT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = sh_q[AW-1:0];
				mem_req.wdata = mem_rdata;
				mem_req.raddr = AW'(sh_q - CW'(2));
			end
			sts_pkg::ST_INS: begin
				mem_req.we = 1'b1;
			end
			sts_pkg::ST_DONE: begin
				res_valid = 1'b1;
			end
			sts_pkg::ST_CMP, sts_pkg::ST_RD_WAIT: begin
			end
			default: begin
			end
		endcase
	end

	assign res = '{
		found:      found_q,
		inserted:   ins_q,
		table_full: full_q,
		position:   pos_q,
		key_out:    kout_q,
		phone_out:  pout_q,
		count_out:  count_q
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sts_pkg::ST_IDLE && in_valid && kind == sts_pkg::KIND_CLEAR) begin
				count_q <= '0;
			end else if (state_q == sts_pkg::ST_INS) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				if (in_valid) begin
					kind_q  <= kind;
					key_q   <= name_key & sts_pkg::KEY_MASK;
					phone_q <= phone;
					lo_q    <= '0;
					hip1_q  <= count_q;
					found_q <= 1'b0;
					ins_q   <= 1'b0;
					full_q  <= (kind == sts_pkg::KIND_ADD) && is_full;
					kout_q  <= '0;
					pout_q  <= '0;
					pos_q   <= (kind == sts_pkg::KIND_READ) ? index : '0;
				end
			end
			sts_pkg::ST_PROBE: begin
				priority if (in_range) begin
					mid_q <= mid;
				end else if (is_full) begin
					full_q <= 1'b1;
					pos_q  <= '0;
				end else begin
					pos_q <= lo_q[AW-1:0];
					sh_q  <= count_q;
				end
			end
			sts_pkg::ST_CMP: begin
				priority if (kind_q == sts_pkg::KIND_SEARCH && key_eq) begin
					found_q <= 1'b1;
					kout_q  <= mem_rdata.key;
					pout_q  <= mem_rdata.phone;
					pos_q   <= mid_q;
				end else if (key_lt || key_eq) begin
					lo_q <= {1'b0, mid_q} + CW'(1);
				end else begin
					hip1_q <= {1'b0, mid_q};
				end
			end
			sts_pkg::ST_SHIFT: begin
				sh_q <= sh_q - CW'(1);
			end
			sts_pkg::ST_INS: begin
				ins_q  <= 1'b1;
				kout_q <= key_q;
				pout_q <= phone_q;
			end
			sts_pkg::ST_RD_WAIT: begin
				kout_q <= mem_rdata.key;
				pout_q <= mem_rdata.phone;
			end
			sts_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hw/rtl/sorted_table_search_insert.sv @@
// Sorted name/phone table, top level: stream ports, output register, table and sequencer.
// Depends on sts_pkg, sts_mem and sts_seq.
`timescale 1ns / 1ps

// Keeps up to 64 entries sorted by name key in one single-port-read RAM and
// serves one word at a time. Kind 0 clears, kind 3 reads an entry, kind 2
// runs a midpoint binary search, each probe passing through a probe state and
// a compare state for the registered RAM read (at most 7 probes), and on a
// miss kind 1 and kind 2 insert after equal keys: entries are moved up one at
// a time in the shift state, then the new entry is written in the insert
// state. Worst case is an insert at the front of 63 entries: 6 probes and 63
// moves. The input is not ready while a word is in work; a finished result
// waits in the output register so the next word can be taken.
module sorted_table_search_insert (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [103:0] s_axis_tdata,  // name_key[63:0], phone[97:64], index[103:98]
	input  logic [1:0]   s_axis_tuser,  // kind[1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata   // found[0], inserted[1], table_full[2],
	                                    // position[8:3], key_out[72:9],
	                                    // phone_out[106:73], count_out[113:107]
);

	sts_pkg::mem_req_t mem_req;
	sts_pkg::entry_t   mem_rdata;
	sts_pkg::result_t  res;
	sts_pkg::result_t  out_q;
	logic              out_valid_q;
	logic              res_valid;
	logic              res_ready;

	assign res_ready = !out_valid_q || m_axis_tready;

	sts_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	sts_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.kind      (sts_pkg::kind_t'(s_axis_tuser)),
		.name_key  (s_axis_tdata[63:0]),
		.phone     (s_axis_tdata[97:64]),
		.index     (s_axis_tdata[103:98]),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_q.count_out, out_q.phone_out, out_q.key_out,
	                        out_q.position, out_q.table_full, out_q.inserted, out_q.found};

endmodule
